/* rtl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

	localparam int MAX_BLOCKS   = 64;
	localparam int ADDR_BITS    = 32;
	localparam int HEADER_BYTES = 16;
	localparam int IDX_W        = $clog2(MAX_BLOCKS);
	localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_ZERO      = 3'd1;
	localparam logic [2:0] ST_EXHAUSTED = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_UNKNOWN   = 3'd4;

	localparam logic CFG_ARENA_BASE  = 1'b0;
	localparam logic CFG_ARENA_BYTES = 1'b1;

	typedef struct packed {
		logic        cmd;
		logic [31:0] request_size;
		logic [31:0] block_address;
	} req_word_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] payload_address;
	} rsp_word_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] offset;
		logic [31:0]          size;
		logic                 free;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} tbl_rd_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
		entry_t           data;
	} tbl_wr_t;

endpackage

/* rtl/ffba_table.sv */
// ----------------------------------------------------------------------------
// ffba_table
// Block table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ffba_table (
	input  logic             clk,
	input  ffba_pkg::tbl_rd_t rd,
	input  ffba_pkg::tbl_wr_t wr,
	output ffba_pkg::entry_t  rd_data
);
	import ffba_pkg::*;

	entry_t mem [MAX_BLOCKS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data <= mem[rd.addr];
		end
	end

endmodule

/* rtl/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Scan sequencer: walks the block table one entry per cycle, then updates it.
// ----------------------------------------------------------------------------
module ffba_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  ffba_pkg::req_word_t req_word,
	input  logic [31:0]         arena_base,
	input  logic [31:0]         arena_bytes,
	output logic                idle,
	output logic                res_valid,
	input  logic                res_ready,
	output ffba_pkg::rsp_word_t res_word,
	output ffba_pkg::tbl_rd_t   rd,
	output ffba_pkg::tbl_wr_t   wr,
	input  ffba_pkg::entry_t    rd_data
);
	import ffba_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SCAN   = 5'b00010,
		S_APPEND = 5'b00100,
		S_RESP   = 5'b01000,
		S_HOLD   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      brk_q;
	logic [CNT_W-1:0] rd_idx_q;
	logic             vld_s1;
	logic [IDX_W-1:0] idx_s1;
	req_word_t        req_q;
	logic [31:0]      base16_q;
	rsp_word_t        res_q;

	logic             hit_alloc;
	logic             hit_free;
	logic             hit;
	logic             is_last;
	logic             scan_done;
	logic             issue;
	logic [33:0]      next_brk;
	logic             exhausted;
	logic             full;

	assign hit_alloc = rd_data.free && (rd_data.size >= req_q.request_size);
	assign hit_free  = (base16_q + rd_data.offset) == req_q.block_address;
	assign hit       = vld_s1 && ((req_q.cmd == CMD_FREE) ? hit_free : hit_alloc);
	assign is_last   = ({1'b0, idx_s1} + CNT_W'(1)) == cnt_q;
	assign scan_done = !vld_s1 && (rd_idx_q == cnt_q);
	assign issue     = (state_q == S_SCAN) && (rd_idx_q < cnt_q) && !hit;
	assign next_brk  = {2'b00, brk_q} + 34'(HEADER_BYTES) + {2'b00, req_q.request_size};
	assign exhausted = next_brk > {2'b00, arena_bytes};
	assign full      = cnt_q >= CNT_W'(MAX_BLOCKS);

	assign idle      = state_q == S_IDLE;
	assign res_valid = state_q == S_RESP;
	assign res_word  = res_q;

	always_comb begin
		rd.en   = issue;
		rd.addr = rd_idx_q[IDX_W-1:0];
		wr      = '0;
		unique case (state_q)
			S_SCAN: begin
				if (hit && req_q.cmd == CMD_ALLOC) begin
					wr.en   = 1'b1;
					wr.addr = idx_s1;
					wr.data = '{offset: rd_data.offset, size: rd_data.size, free: 1'b0};
				end else if (hit && !is_last) begin
					wr.en   = 1'b1;
					wr.addr = idx_s1;
					wr.data = '{offset: rd_data.offset, size: rd_data.size, free: 1'b1};
				end
			end
			S_APPEND: begin
				if (!exhausted && !full) begin
					wr.en   = 1'b1;
					wr.addr = cnt_q[IDX_W-1:0];
					wr.data = '{offset: brk_q, size: req_q.request_size, free: 1'b0};
				end
			end
			S_IDLE, S_RESP, S_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			brk_q    <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						rd_idx_q <= '0;
						if (req_word.cmd == CMD_ALLOC && req_word.request_size == '0) begin
							state_q <= S_HOLD;
						end else if (req_word.cmd == CMD_FREE && req_word.block_address == '0) begin
							state_q <= S_HOLD;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit) begin
						if (req_q.cmd == CMD_FREE && is_last) begin
							cnt_q <= cnt_q - CNT_W'(1);
							brk_q <= rd_data.offset;
						end
						state_q <= S_RESP;
					end else if (scan_done) begin
						state_q <= (req_q.cmd == CMD_ALLOC) ? S_APPEND : S_RESP;
					end
				end
				S_APPEND: begin
					if (!exhausted && !full) begin
						cnt_q <= cnt_q + CNT_W'(1);
						brk_q <= next_brk[31:0];
					end
					state_q <= S_RESP;
				end
				S_HOLD: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_q    <= req_word;
					base16_q <= arena_base + 32'(HEADER_BYTES);
					res_q    <= '{status: (req_word.cmd == CMD_ALLOC) ? ST_ZERO : ST_OK,
						payload_address: '0};
				end
			end
			S_SCAN: begin
				if (hit) begin
					res_q.status          <= ST_OK;
					res_q.payload_address <= (req_q.cmd == CMD_ALLOC) ?
						(base16_q + rd_data.offset) : '0;
				end else if (scan_done) begin
					res_q <= '{status: ST_UNKNOWN, payload_address: '0};
				end
			end
			S_APPEND: begin
				if (exhausted) begin
					res_q <= '{status: ST_EXHAUSTED, payload_address: '0};
				end else if (full) begin
					res_q <= '{status: ST_FULL, payload_address: '0};
				end else begin
					res_q <= '{status: ST_OK, payload_address: base16_q + brk_q};
				end
			end
			S_RESP, S_HOLD: begin
			end
			default: begin
			end
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_BLOCKS))
		else $error("entry count above table depth");

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (state_q == S_SCAN || state_q == S_APPEND))
		else $error("table write outside scan or append");

	a_cnt_change: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_SCAN || $past(state_q) == S_APPEND))
		else $error("entry count moved outside scan or append");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(idle && start) |=> !idle)
		else $error("accepted word did not start an operation");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> (rd_idx_q < cnt_q))
		else $error("table read beyond entry count");

endmodule

/* rtl/first_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator over an address-ordered block table.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_word) takes one command word:
//   allocate a size, or free a payload address. rsp channel (rsp_valid /
//   rsp_stall / rsp_word) returns one status word per command.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes
//   arena_base (index 0) and arena_bytes (index 1); write it only when idle.
// Sequencing:
//   One command at a time. A zero-size allocate or a free of address 0
//   skips the scan and goes through a hold state to the response. Other
//   commands scan the table held in a single-port-read memory, one entry
//   per cycle; the memory read port sets the scan rate.
//   req_stall is high while a command is in flight.
// Reset:
//   arst_n clears the entry count and break; table contents need no clear.
//   arena_base resets to 0 and arena_bytes to all ones.
// Stall:
//   The response waits in an output register while rsp_stall is high; the
//   next command is accepted meanwhile and its result holds until that slot
//   drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  ffba_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ffba_pkg::rsp_word_t rsp_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [31:0]         cfg_data
);
	import ffba_pkg::*;

	logic        arena_base_q;
	logic [31:0] base_q;
	logic [31:0] bytes_q;
	logic        idle;
	logic        res_valid;
	logic        res_ready;
	rsp_word_t   res_word;
	tbl_rd_t     rd;
	tbl_wr_t     wr;
	entry_t      rd_data;
	logic        out_valid_q;
	rsp_word_t   out_q;

	assign arena_base_q = cfg_index == CFG_ARENA_BASE;
	assign cfg_ready    = 1'b1;
	assign req_stall    = !idle;
	assign res_ready    = !out_valid_q || !rsp_stall;
	assign rsp_valid    = out_valid_q;
	assign rsp_word     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bytes_q <= '1;
		end else if (cfg_valid && cfg_ready) begin
			if (arena_base_q) begin
				base_q <= cfg_data;
			end else begin
				bytes_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_word;
		end
	end

	ffba_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (req_valid && !req_stall),
		.req_word    (req_word),
		.arena_base  (base_q),
		.arena_bytes (bytes_q),
		.idle        (idle),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_word    (res_word),
		.rd          (rd),
		.wr          (wr),
		.rd_data     (rd_data)
	);

	ffba_table u_table (
		.clk     (clk),
		.rd      (rd),
		.wr      (wr),
		.rd_data (rd_data)
	);

endmodule
